// ----- rtl/key_event_detector_macros.svh -----
// ----------------------------------------------------------------------------
// key_event_detector_macros.svh
// Assertion macros used by the key event detector core RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_EVENT_DETECTOR_MACROS_SVH
`define KEY_EVENT_DETECTOR_MACROS_SVH

// Invariant checked on every clock edge outside reset.
`define KED_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define KED_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KED_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ked_pkg.sv -----
// ----------------------------------------------------------------------------
// ked_pkg
// Types and constants of the key event detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ked_pkg;

    localparam int KEY_BITS = 8;
    localparam logic [7:0] KEY_MASK = 8'((64'd1 << KEY_BITS) - 64'd1);

    localparam logic [7:0] HOLD_RESET = 8'd100;
    localparam logic [7:0] TICK_MAX   = 8'd255;

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_START = 2'd0,
        ST_CHECK = 2'd1,
        ST_DOWN  = 2'd2,
        ST_PAUSE = 2'd3
    } t_state;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_HOLD = 2'd2,
        EV_UP   = 2'd3
    } t_ev_code;

    typedef struct packed {
        logic       req_type;
        logic [7:0] key_sample;
    } t_req_item;

    typedef struct packed {
        logic       ev_valid;
        logic [7:0] ev_key;
        t_ev_code   ev_code;
        logic [7:0] press_edges;
    } t_res_item;

endpackage

`default_nettype wire

// ----- rtl/ked_core.sv -----
// ----------------------------------------------------------------------------
// ked_core
// Key state machine, hold counter and one-slot event mailbox.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_event_detector_macros.svh"

module ked_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [7:0]       i_cfg_wdata,
    input  wire logic             i_step,
    input  wire ked_pkg::t_req_item i_item,
    output ked_pkg::t_res_item    o_result
);
    import ked_pkg::*;

    logic [7:0] r_hold_thr;
    logic [7:0] r_last_keys, n_last_keys;
    logic [7:0] r_older_keys, n_older_keys;
    t_state     r_state, n_state;
    logic [7:0] r_tick, n_tick;
    logic [7:0] r_mail_key, n_mail_key;
    t_ev_code   r_mail_code, n_mail_code;

    logic [7:0] sample;
    logic [7:0] edges;
    logic [7:0] tick_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_thr   <= HOLD_RESET;
            r_last_keys  <= '0;
            r_older_keys <= '0;
            r_state      <= ST_START;
            r_tick       <= '0;
            r_mail_key   <= '0;
            r_mail_code  <= EV_NONE;
        end else begin
            if (i_cfg_we) begin
                r_hold_thr <= i_cfg_wdata;
            end
            if (i_step) begin
                r_last_keys  <= n_last_keys;
                r_older_keys <= n_older_keys;
                r_state      <= n_state;
                r_tick       <= n_tick;
                r_mail_key   <= n_mail_key;
                r_mail_code  <= n_mail_code;
            end
        end
    end

    always_comb begin
        sample   = i_item.key_sample & KEY_MASK;
        edges    = sample & ~r_last_keys & KEY_MASK;
        tick_inc = (r_tick < TICK_MAX) ? (r_tick + 8'd1) : r_tick;

        n_last_keys  = r_last_keys;
        n_older_keys = r_older_keys;
        n_state      = r_state;
        n_tick       = r_tick;
        n_mail_key   = r_mail_key;
        n_mail_code  = r_mail_code;

        if (i_item.req_type == REQ_READ) begin
            // read and clear; scan state untouched
            n_mail_key  = '0;
            n_mail_code = EV_NONE;
            o_result.ev_valid    = (r_mail_code != EV_NONE);
            o_result.ev_key      = (r_mail_code != EV_NONE) ? r_mail_key : 8'd0;
            o_result.ev_code     = r_mail_code;
            o_result.press_edges = '0;
        end else begin
            n_last_keys  = sample;
            n_older_keys = sample;
            case (r_state)
                ST_START: begin
                    n_state = ST_CHECK;
                end
                ST_CHECK: begin
                    if (edges != 8'd0) begin
                        n_mail_key  = edges;
                        n_mail_code = EV_DOWN;
                        n_tick      = '0;
                        n_state     = ST_DOWN;
                    end
                end
                ST_DOWN: begin
                    if (sample == r_older_keys) begin
                        n_tick = tick_inc;
                        if (tick_inc > r_hold_thr) begin
                            n_mail_key  = sample;
                            n_mail_code = EV_HOLD;
                            n_state     = ST_PAUSE;
                        end
                    end else begin
                        n_mail_key  = r_older_keys;
                        n_mail_code = EV_UP;
                        n_state     = ST_PAUSE;
                    end
                end
                default: begin
                    n_state = ST_CHECK;
                end
            endcase
            o_result.ev_valid    = (n_mail_code != EV_NONE);
            o_result.ev_key      = n_mail_key;
            o_result.ev_code     = n_mail_code;
            o_result.press_edges = edges;
        end
    end

    `KED_ASSERT_IMP(a_mail_empty_key_zero, r_mail_code == EV_NONE, r_mail_key == 8'd0, "mailbox empty with nonzero key")
    `KED_ASSERT(a_older_tracks_last, r_older_keys == r_last_keys, "older_keys diverged from last_keys")
    `KED_ASSERT_NXT(a_down_entry_clears_tick, i_step && (i_item.req_type == REQ_SCAN) && (r_state == ST_CHECK) && (edges != 8'd0), (r_state == ST_DOWN) && (r_tick == 8'd0), "down entry without tick clear")

endmodule

`default_nettype wire

// ----- rtl/key_event_detector.sv -----
// ----------------------------------------------------------------------------
// key_event_detector
// Key press / hold / release detector with a one-slot event mailbox.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready, i_item): each item is either a scan
//   tick carrying a raw key bitmap or a read that returns and clears the
//   mailbox. Output channel (o_valid / i_ready, o_result): exactly one
//   result item per input item, in order.
//   Config: i_cfg_we writes hold_threshold from i_cfg_wdata;
//   write only while no item is in flight.
//   Path: an accepted item waits in the input register; when the output
//   is free, its result is registered in the result register for o_result.
//   Throughput: one item per cycle unless i_ready stalls; the input register
//   feeds a single pass of the state machine logic into the result register.
//   Stall: while i_ready is low the result register holds; the input
//   register still takes one more item, then o_ready drops until the
//   result drains.
//   Reset: synchronous active low; clears both stage valid bits, the state
//   machine, key history, hold counter, mailbox; loads hold_threshold = 100.
// ----------------------------------------------------------------------------
`default_nettype none

module key_event_detector (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [7:0]         i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire ked_pkg::t_req_item i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output ked_pkg::t_res_item      o_result
);
    import ked_pkg::*;

    logic      r_in_valid;
    t_req_item r_in_item;
    logic      r_out_valid;
    t_res_item r_out_item;

    logic      out_free;
    logic      step;
    t_res_item core_result;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_in_valid || out_free;
    assign step     = r_in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload stages, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_item <= i_item;
        end
        if (step) begin
            r_out_item <= core_result;
        end
    end

    ked_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_item      (r_in_item),
        .o_result    (core_result)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out_item;

endmodule

`default_nettype wire
